// ----- design/lccs_pkg.sv -----
// Shared types, codes and threshold table of the load to core count selector.
`default_nettype none

package lccs_pkg;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_RAISE = 2'd1,
        ACT_LOWER = 2'd2,
        ACT_HELD  = 2'd3
    } t_action;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_TOUCH  = 1'b1
    } t_operation;

    typedef struct packed {
        t_operation  operation;
        logic [31:0] load_avg;
        logic [63:0] now_us;
        logic [2:0]  online_cores;
    } t_in_item;

    typedef struct packed {
        logic [2:0] target_cores;
        t_action    action;
    } t_out_item;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CORES     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CORES     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST_CORES   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PROFILE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST_LOCK_US = 3'd4;

    localparam logic [2:0]  RST_MIN_CORES     = 3'd1;
    localparam logic [2:0]  RST_MAX_CORES     = 3'd4;
    localparam logic [2:0]  RST_BOOST_CORES   = 3'd2;
    localparam logic [1:0]  RST_PROFILE       = 2'd0;
    localparam logic [31:0] RST_BOOST_LOCK_US = 32'd500000;

    localparam logic [63:0] TOUCH_GAP_US = 64'd150000;

    // Table codes 0 to 3 are the four-core profiles; 4, 5 and 6 serve
    // three, two and one core.
    localparam logic [2:0] TAB_THREE = 3'd4;
    localparam logic [2:0] TAB_TWO   = 3'd5;
    localparam logic [2:0] TAB_ONE   = 3'd6;

    function automatic logic [4:0] thr_lookup(input logic [2:0] tab, input logic [1:0] idx);
        logic [4:0] v;
        v = 5'd0;
        unique case ({tab, idx})
            {3'd0, 2'd0}: v = 5'd7;
            {3'd0, 2'd1}: v = 5'd10;
            {3'd0, 2'd2}: v = 5'd13;
            {3'd1, 2'd0}: v = 5'd4;
            {3'd1, 2'd1}: v = 5'd7;
            {3'd1, 2'd2}: v = 5'd10;
            {3'd2, 2'd0}: v = 5'd10;
            {3'd2, 2'd1}: v = 5'd18;
            {3'd2, 2'd2}: v = 5'd24;
            {3'd4, 2'd0}: v = 5'd7;
            {3'd4, 2'd1}: v = 5'd10;
            {3'd5, 2'd0}: v = 5'd4;
            default:      v = 5'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- design/load_to_core_count_selector_unit.sv -----
// Top level of the load to core count selector.
//
// The input channel carries items that are either a load sample or a touch
// event; every item yields exactly one result item holding the wanted core
// count and the action to take. Both channels use valid and stall, and an
// item moves at a clock edge where valid is high and stall is low.
// An accepted item lands in an input register, is evaluated combinationally
// and is written to the result register. One item is taken every cycle while
// the output side keeps up; the single compare-and-clamp stage sets that rate.
// When the receiver stalls, the result holds and the input register still
// takes one more item; after that the input side stalls as well.
// The configuration port is a plain write port; the user writes it only
// while the block is idle, which the block itself does not enforce. A
// synchronous active-low reset empties both registers, loads the register
// reset values and clears the level and time history.
`default_nettype none

module load_to_core_count_selector_unit #(
    parameter int unsigned MAX_CORE_COUNT = 4,
    parameter int unsigned LOAD_FRAC_BITS = 11
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire lccs_pkg::t_in_item                   i_in_item,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output lccs_pkg::t_out_item                       o_out_item,
    input  wire logic                                 i_cfg_we,
    input  wire logic [lccs_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [lccs_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int unsigned TW = 6 + LOAD_FRAC_BITS;
    localparam logic [2:0]  MAX_LIM = 3'(MAX_CORE_COUNT);

    logic [2:0]         r_min;
    logic [2:0]         r_max;
    logic [2:0]         r_boost;
    logic [1:0]         r_profile;
    logic [31:0]        r_lock_us;

    logic               r_in_valid;
    lccs_pkg::t_in_item r_in;
    logic               r_out_valid;
    lccs_pkg::t_out_item r_out;
    lccs_pkg::t_out_item n_out;

    logic [2:0]         r_last_level;
    logic [2:0]         n_last_level;
    logic [63:0]        r_last_touch;
    logic [63:0]        n_last_touch;
    logic [63:0]        r_last_boost;
    logic [63:0]        n_last_boost;

    logic               advance;
    logic               accept;
    logic [2:0]         lo;
    logic [2:0]         hi;

    function automatic logic [2:0] lim(input logic [2:0] v);
        logic [2:0] r;
        r = v;
        if (v == 3'd0) begin
            r = 3'd1;
        end else if (v > MAX_LIM) begin
            r = MAX_LIM;
        end
        return r;
    endfunction

    function automatic lccs_pkg::t_out_item decide(
        input logic [2:0] want,
        input logic [2:0] online,
        input logic [2:0] lo_v,
        input logic [2:0] hi_v,
        input logic [2:0] boost,
        input logic       locked
    );
        lccs_pkg::t_out_item o;
        logic [2:0] t;
        t = want;
        if (t < lo_v) begin
            t = lo_v;
        end else if (t > hi_v) begin
            t = hi_v;
        end
        o.target_cores = t;
        o.action = lccs_pkg::ACT_NONE;
        if (t < online) begin
            if (online <= boost && locked) begin
                o.action = lccs_pkg::ACT_HELD;
            end else begin
                o.action = lccs_pkg::ACT_LOWER;
            end
        end else if (t > online) begin
            o.action = lccs_pkg::ACT_RAISE;
        end else begin
            o.target_cores = online;
        end
        return o;
    endfunction

    assign advance = !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !advance;
    assign accept  = i_valid && !o_stall;
    assign lo      = lim(r_min);
    assign hi      = lim(r_max);

    always_comb begin
        logic [2:0]    top;
        logic [2:0]    tab;
        logic [4:0]    shamt;
        logic [5:0]    thr;
        logic [TW-1:0] thr_sh;
        logic [2:0]    lvl;
        logic          found;
        logic          lock_cmp;
        logic [63:0]   touch_gap;

        top       = hi;
        tab       = lccs_pkg::TAB_ONE;
        shamt     = 5'(LOAD_FRAC_BITS) - 5'(top) + 5'd1;
        lvl       = top;
        found     = 1'b0;
        thr       = 6'd0;
        thr_sh    = '0;
        lock_cmp  = (r_in.now_us - r_last_touch) < {32'd0, r_lock_us};
        touch_gap = r_in.now_us - r_last_boost;

        if (top >= 3'd4) begin
            tab = {1'b0, r_profile};
        end else if (top == 3'd3) begin
            tab = lccs_pkg::TAB_THREE;
        end else if (top == 3'd2) begin
            tab = lccs_pkg::TAB_TWO;
        end

        for (int k = 1; k < 4; k++) begin
            if (!found && 3'(k) < top) begin
                thr = {1'b0, lccs_pkg::thr_lookup(tab, 2'(k - 1))};
                if (r_last_level <= 3'(k)) begin
                    thr = thr + {2'b00, top, 1'b0};
                end
                thr_sh = TW'(thr) << shamt;
                if (r_in.load_avg <= 32'(thr_sh)) begin
                    found = 1'b1;
                    lvl   = 3'(k);
                end
            end
        end

        n_out.target_cores = r_in.online_cores;
        n_out.action       = lccs_pkg::ACT_NONE;
        n_last_level       = r_last_level;
        n_last_touch       = r_last_touch;
        n_last_boost       = r_last_boost;

        if (r_in.operation == lccs_pkg::OP_SAMPLE) begin
            n_last_level = lvl;
            n_out = decide(lvl, r_in.online_cores, lo, hi, r_boost, lock_cmp);
        end else if (r_boost != 3'd1) begin
            n_last_touch = r_in.now_us;
            if (touch_gap >= lccs_pkg::TOUCH_GAP_US
                    && r_in.online_cores < r_boost && r_boost > lo) begin
                // The touch time was just recorded, so the lock runs unless it is zero.
                n_out = decide(r_boost, r_in.online_cores, lo, hi, r_boost,
                               r_lock_us != 32'd0);
                n_last_boost = r_in.now_us;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min     <= lccs_pkg::RST_MIN_CORES;
            r_max     <= lccs_pkg::RST_MAX_CORES;
            r_boost   <= lccs_pkg::RST_BOOST_CORES;
            r_profile <= lccs_pkg::RST_PROFILE;
            r_lock_us <= lccs_pkg::RST_BOOST_LOCK_US;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lccs_pkg::CFG_MIN_CORES:     r_min     <= i_cfg_data[2:0];
                lccs_pkg::CFG_MAX_CORES:     r_max     <= i_cfg_data[2:0];
                lccs_pkg::CFG_BOOST_CORES:   r_boost   <= i_cfg_data[2:0];
                lccs_pkg::CFG_PROFILE:       r_profile <= i_cfg_data[1:0];
                lccs_pkg::CFG_BOOST_LOCK_US: r_lock_us <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_last_level <= 3'd0;
            r_last_touch <= 64'd0;
            r_last_boost <= 64'd0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (advance && r_in_valid) begin
                r_last_level <= n_last_level;
                r_last_touch <= n_last_touch;
                r_last_boost <= n_last_boost;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_item;
        end
        if (advance && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_item = r_out;

endmodule

`default_nettype wire

// ----- design/lccs_checker.sv -----
// Port-level checker for the load to core count selector and its bind.
`default_nettype none

module lccs_checker #(
    parameter int unsigned MAX_CORE_COUNT = 4
) (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_valid,
    input wire logic                o_stall,
    input wire logic                o_valid,
    input wire logic                i_stall,
    input wire lccs_pkg::t_out_item o_out_item
);

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while the result side can move");

    a_result_follows_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> ##1 o_valid)
        else $error("accepted item produced no result in time");

    a_action_target_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_item.action != lccs_pkg::ACT_NONE) |->
            (o_out_item.target_cores != 3'd0
             && o_out_item.target_cores <= 3'(MAX_CORE_COUNT)))
        else $error("core count outside the limits on an action");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_item)))
        else $error("stalled result item changed");

endmodule

bind load_to_core_count_selector_unit lccs_checker #(
    .MAX_CORE_COUNT(MAX_CORE_COUNT)
) u_lccs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_out_item (o_out_item)
);

`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for the load to core count selector: directed table, then random phases.
`timescale 1ns / 1ps

module tb;

    localparam int unsigned CORE_LIMIT = 4;
    localparam int unsigned FRAC_BITS  = 11;
    localparam int unsigned CORE_CAP   = 339 - 50;

    localparam int unsigned PROF_BALANCE  = 0;
    localparam int unsigned PROF_PERF     = 1;
    localparam int unsigned PROF_CONSERVE = 2;
    localparam int unsigned PROF_DISABLE  = 3;

    localparam int PHASES     = 12;
    localparam int PHASE_LEN  = 50;

    typedef enum logic {
        ROW_ITEM,
        ROW_REG
    } t_row_kind;

    typedef struct {
        t_row_kind           kind;
        lccs_pkg::t_in_item  it;
        bit                  known;
        lccs_pkg::t_out_item res;
        logic [2:0]          idx;
        logic [31:0]         val;
    } t_row;

    typedef struct {
        bit                  known;
        lccs_pkg::t_out_item res;
    } t_typed;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_valid;
    logic                            o_stall;
    lccs_pkg::t_in_item              i_in_item;
    logic                            o_valid;
    logic                            i_stall;
    lccs_pkg::t_out_item             o_out_item;
    logic                            i_cfg_we;
    logic [lccs_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [lccs_pkg::CFG_DATA_W-1:0] i_cfg_data;

    // Mirror of the block's registers and history.
    int unsigned     cfg_min, cfg_max, cfg_boost, cfg_profile;
    longint unsigned cfg_lock;
    int unsigned     prev_level;
    longint unsigned touch_stamp, boost_stamp;

    lccs_pkg::t_out_item pending_results[$];
    t_typed              typed_results[$];

    int n_items, n_touch, n_results, n_regs, n_errors;
    int tx_idle_pct, rx_idle_pct, stall_hold;
    longint unsigned sim_now;

    load_to_core_count_selector_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in_item  (i_in_item),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_item (o_out_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int unsigned clamp_limit(input int unsigned v);
        if (v == 0) begin
            return 1;
        end
        if (v > CORE_LIMIT) begin
            return CORE_LIMIT;
        end
        return v;
    endfunction

    function automatic longint unsigned step_threshold(input int unsigned tab,
                                                       input int unsigned idx);
        int unsigned k;
        k = 0;
        case (tab)
            PROF_BALANCE:  k = (idx == 0) ? 625 : (idx == 1) ? 875 : 1125;
            PROF_PERF:     k = (idx == 0) ? 380 : (idx == 1) ? 625 : 875;
            PROF_CONSERVE: k = (idx == 0) ? 875 : (idx == 1) ? 1625 : 2125;
            lccs_pkg::TAB_THREE: k = (idx == 0) ? 625 : (idx == 1) ? 875 : 0;
            lccs_pkg::TAB_TWO:   k = (idx == 0) ? 380 : 0;
            default:       k = 0;
        endcase
        return (CORE_CAP * k * 4) / 100000;
    endfunction

    function automatic int unsigned choose_level(input longint unsigned load);
        int unsigned     top, tab, shift, lvl;
        longint unsigned bar;
        bit              found;
        top = clamp_limit(cfg_max);
        if (top >= 4) begin
            tab = cfg_profile;
        end else if (top == 3) begin
            tab = lccs_pkg::TAB_THREE;
        end else if (top == 2) begin
            tab = lccs_pkg::TAB_TWO;
        end else begin
            tab = lccs_pkg::TAB_ONE;
        end
        shift = FRAC_BITS - (top - 1);
        lvl = 1;
        found = 1'b0;
        while (lvl < top && !found) begin
            bar = step_threshold(tab, lvl - 1);
            if (prev_level <= lvl) begin
                bar = bar + top * 2;
            end
            if (load <= (bar << shift)) begin
                found = 1'b1;
            end else begin
                lvl++;
            end
        end
        prev_level = lvl & 7;
        return lvl;
    endfunction

    function automatic lccs_pkg::t_out_item settle_target(input int unsigned want,
                                                          input int unsigned online,
                                                          input longint unsigned now);
        int unsigned         lo, hi, t;
        lccs_pkg::t_out_item res;
        lo = clamp_limit(cfg_min);
        hi = clamp_limit(cfg_max);
        t = want;
        res.action = lccs_pkg::ACT_NONE;
        if (t < lo) begin
            t = lo;
        end else if (t > hi) begin
            t = hi;
        end
        if (t < online) begin
            if (online <= cfg_boost && (now - touch_stamp) < cfg_lock) begin
                res.action = lccs_pkg::ACT_HELD;
            end else begin
                res.action = lccs_pkg::ACT_LOWER;
            end
        end else if (t > online) begin
            res.action = lccs_pkg::ACT_RAISE;
        end
        res.target_cores = 3'(t);
        return res;
    endfunction

    function automatic lccs_pkg::t_out_item predict_result(input lccs_pkg::t_in_item it);
        int unsigned         online;
        longint unsigned     now;
        lccs_pkg::t_out_item res;
        online = int'(it.online_cores);
        now = it.now_us;
        res.target_cores = it.online_cores;
        res.action = lccs_pkg::ACT_NONE;
        if (it.operation == lccs_pkg::OP_SAMPLE) begin
            return settle_target(choose_level(longint'(it.load_avg)), online, now);
        end
        if (cfg_boost == 1) begin
            return res;
        end
        touch_stamp = now;
        if ((now - boost_stamp) < lccs_pkg::TOUCH_GAP_US) begin
            return res;
        end
        if (online >= cfg_boost || cfg_boost <= clamp_limit(cfg_min)) begin
            return res;
        end
        res = settle_target(cfg_boost, online, now);
        boost_stamp = now;
        return res;
    endfunction

    function automatic t_row item_row(input lccs_pkg::t_operation op,
                                      input logic [31:0] load,
                                      input logic [63:0] now, input logic [2:0] online);
        t_row r;
        r.kind = ROW_ITEM;
        r.it.operation = op;
        r.it.load_avg = load;
        r.it.now_us = now;
        r.it.online_cores = online;
        r.known = 1'b0;
        r.res = '0;
        r.idx = '0;
        r.val = '0;
        return r;
    endfunction

    function automatic t_row typed_row(input lccs_pkg::t_operation op,
                                       input logic [31:0] load,
                                       input logic [63:0] now, input logic [2:0] online,
                                       input logic [2:0] target,
                                       input lccs_pkg::t_action act);
        t_row r;
        r = item_row(op, load, now, online);
        r.known = 1'b1;
        r.res.target_cores = target;
        r.res.action = act;
        return r;
    endfunction

    function automatic t_row reg_row(input logic [2:0] idx, input logic [31:0] val);
        t_row r;
        r = item_row(lccs_pkg::OP_SAMPLE, '0, '0, '0);
        r.kind = ROW_REG;
        r.idx = idx;
        r.val = val;
        return r;
    endfunction

    task automatic flag_error(input string msg);
        n_errors++;
        if (n_errors <= 10) begin
            $display("ERROR: %s", msg);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        lccs_pkg::t_out_item want;
        t_typed              fix;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                n_results++;
                if (pending_results.size() == 0) begin
                    flag_error($sformatf("result target %0d action %0d with no item pending",
                                         o_out_item.target_cores, o_out_item.action));
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_item.target_cores !== want.target_cores) begin
                        flag_error($sformatf("target_cores expected %0d got %0d",
                                             want.target_cores, o_out_item.target_cores));
                    end
                    if (o_out_item.action !== want.action) begin
                        flag_error($sformatf("action expected %0d got %0d",
                                             want.action, o_out_item.action));
                    end
                end
            end
            if (i_valid && !o_stall) begin
                want = predict_result(i_in_item);
                if (typed_results.size() != 0) begin
                    fix = typed_results.pop_front();
                    if (fix.known) begin
                        want = fix.res;
                    end
                end
                pending_results.push_back(want);
            end
        end
    end

    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_hold > 0) begin
                i_stall <= 1'b1;
                stall_hold--;
            end else begin
                i_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    task automatic send_item(input lccs_pkg::t_in_item it, input bit known,
                             input lccs_pkg::t_out_item res);
        t_typed fix;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        fix.known = known;
        fix.res = res;
        typed_results.push_back(fix);
        n_items++;
        if (it.operation == lccs_pkg::OP_TOUCH) begin
            n_touch++;
        end
        i_valid <= 1'b1;
        i_in_item <= it;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [lccs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        n_regs++;
        case (idx)
            lccs_pkg::CFG_MIN_CORES:     cfg_min = val & 7;
            lccs_pkg::CFG_MAX_CORES:     cfg_max = val & 7;
            lccs_pkg::CFG_BOOST_CORES:   cfg_boost = val & 7;
            lccs_pkg::CFG_PROFILE:       cfg_profile = val & 3;
            lccs_pkg::CFG_BOOST_LOCK_US: cfg_lock = longint'(val);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [2:0] pick_core_reg();
        if ($urandom_range(7) == 0) begin
            return 3'($urandom_range(7));
        end
        return 3'($urandom_range(4, 1));
    endfunction

    task automatic configure_phase(input int p);
        logic [2:0]  mn, mx, bst;
        logic [1:0]  prof;
        logic [31:0] lock;
        mn = pick_core_reg();
        mx = pick_core_reg();
        bst = pick_core_reg();
        prof = 2'($urandom_range(3));
        case ($urandom_range(4))
            0:       lock = '0;
            1:       lock = '1;
            2:       lock = lccs_pkg::RST_BOOST_LOCK_US;
            3:       lock = $urandom_range(2000000);
            default: lock = $urandom;
        endcase
        case (p)
            0: begin
                mn = lccs_pkg::RST_MIN_CORES;
                mx = lccs_pkg::RST_MAX_CORES;
                bst = lccs_pkg::RST_BOOST_CORES;
                prof = lccs_pkg::RST_PROFILE;
                lock = lccs_pkg::RST_BOOST_LOCK_US;
            end
            1: begin
                mn = 3'd4;
                mx = 3'd4;
                bst = 3'd4;
                prof = 2'(PROF_DISABLE);
                lock = '0;
            end
            2: begin
                mn = 3'd1;
                mx = 3'd1;
                bst = 3'd1;
                lock = '1;
            end
            3: begin
                mn = 3'd0;
                mx = 3'd7;
                bst = 3'd7;
                prof = 2'(PROF_PERF);
            end
            4: begin
                mn = 3'd3;
                mx = 3'd2;
                bst = 3'd3;
                prof = 2'(PROF_CONSERVE);
            end
            default: ;
        endcase
        write_reg(lccs_pkg::CFG_MIN_CORES, {29'd0, mn});
        write_reg(lccs_pkg::CFG_MAX_CORES, {29'd0, mx});
        write_reg(lccs_pkg::CFG_BOOST_CORES, {29'd0, bst});
        write_reg(lccs_pkg::CFG_PROFILE, {30'd0, prof});
        write_reg(lccs_pkg::CFG_BOOST_LOCK_US, lock);
    endtask

    function automatic lccs_pkg::t_in_item random_item();
        lccs_pkg::t_in_item it;
        it.operation = ($urandom_range(3) == 0) ? lccs_pkg::OP_TOUCH : lccs_pkg::OP_SAMPLE;
        case ($urandom_range(9))
            0:       it.load_avg = $urandom;
            1:       it.load_avg = '0;
            2:       it.load_avg = $urandom_range(65535);
            default: it.load_avg = $urandom_range(12000);
        endcase
        sim_now = sim_now + $urandom_range(250000);
        it.now_us = sim_now;
        if ($urandom_range(9) == 0) begin
            it.online_cores = 3'($urandom_range(7));
        end else begin
            it.online_cores = 3'($urandom_range(4, 1));
        end
        return it;
    endfunction

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin : main
        t_row                plan[$];
        t_row                r;
        lccs_pkg::t_out_item none_res;
        int                  p, k;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_in_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        tx_idle_pct = 37;
        rx_idle_pct = 37;
        stall_hold = 0;
        n_items = 0;
        n_touch = 0;
        n_results = 0;
        n_regs = 0;
        n_errors = 0;
        none_res = '0;
        cfg_min = lccs_pkg::RST_MIN_CORES;
        cfg_max = lccs_pkg::RST_MAX_CORES;
        cfg_boost = lccs_pkg::RST_BOOST_CORES;
        cfg_profile = lccs_pkg::RST_PROFILE;
        cfg_lock = lccs_pkg::RST_BOOST_LOCK_US;
        prev_level = 0;
        touch_stamp = 0;
        boost_stamp = 0;

        plan.push_back(typed_row(lccs_pkg::OP_SAMPLE, 32'd0, 64'd1000, 3'd1,
                                 3'd1, lccs_pkg::ACT_NONE));
        plan.push_back(typed_row(lccs_pkg::OP_SAMPLE, '1, 64'd2000, 3'd1,
                                 3'd4, lccs_pkg::ACT_RAISE));
        plan.push_back(typed_row(lccs_pkg::OP_SAMPLE, 32'd0, 64'd3000, 3'd4,
                                 3'd1, lccs_pkg::ACT_LOWER));
        plan.push_back(typed_row(lccs_pkg::OP_TOUCH, 32'd0, 64'd1000000, 3'd1,
                                 3'd2, lccs_pkg::ACT_RAISE));
        plan.push_back(typed_row(lccs_pkg::OP_SAMPLE, 32'd0, 64'd1100000, 3'd2,
                                 3'd1, lccs_pkg::ACT_HELD));
        plan.push_back(typed_row(lccs_pkg::OP_TOUCH, 32'd0, 64'd1100001, 3'd1,
                                 3'd1, lccs_pkg::ACT_NONE));
        plan.push_back(typed_row(lccs_pkg::OP_SAMPLE, 32'd0, 64'd1599000, 3'd2,
                                 3'd1, lccs_pkg::ACT_HELD));
        plan.push_back(typed_row(lccs_pkg::OP_SAMPLE, 32'd0, 64'd1600001, 3'd2,
                                 3'd1, lccs_pkg::ACT_LOWER));
        plan.push_back(typed_row(lccs_pkg::OP_TOUCH, 32'd0, 64'd2000000, 3'd2,
                                 3'd2, lccs_pkg::ACT_NONE));
        plan.push_back(typed_row(lccs_pkg::OP_TOUCH, 32'd0, 64'd3000000, 3'd0,
                                 3'd2, lccs_pkg::ACT_RAISE));
        plan.push_back(typed_row(lccs_pkg::OP_SAMPLE, 32'd0, 64'd3000100, 3'd7,
                                 3'd1, lccs_pkg::ACT_LOWER));
        plan.push_back(item_row(lccs_pkg::OP_SAMPLE, 32'd3840, 64'd3000200, 3'd1));
        plan.push_back(item_row(lccs_pkg::OP_SAMPLE, 32'd3841, 64'd3000300, 3'd1));
        plan.push_back(item_row(lccs_pkg::OP_SAMPLE, 32'd0, '1, 3'd3));
        plan.push_back(item_row(lccs_pkg::OP_TOUCH, '1, 64'hFFFF_FFFF_FFFF_FFF0, 3'd0));
        plan.push_back(reg_row(lccs_pkg::CFG_PROFILE, PROF_PERF));
        plan.push_back(item_row(lccs_pkg::OP_SAMPLE, 32'd4000, 64'd5000000, 3'd2));
        plan.push_back(reg_row(lccs_pkg::CFG_PROFILE, PROF_CONSERVE));
        plan.push_back(item_row(lccs_pkg::OP_SAMPLE, 32'd6000, 64'd5000100, 3'd2));
        plan.push_back(reg_row(lccs_pkg::CFG_PROFILE, PROF_DISABLE));
        plan.push_back(item_row(lccs_pkg::OP_SAMPLE, 32'd1, 64'd5000200, 3'd1));
        plan.push_back(reg_row(lccs_pkg::CFG_MAX_CORES, 32'd0));
        plan.push_back(typed_row(lccs_pkg::OP_SAMPLE, '1, 64'd5000300, 3'd1,
                                 3'd1, lccs_pkg::ACT_NONE));
        plan.push_back(reg_row(lccs_pkg::CFG_MAX_CORES, 32'd3));
        plan.push_back(reg_row(lccs_pkg::CFG_MIN_CORES, 32'd7));
        plan.push_back(item_row(lccs_pkg::OP_SAMPLE, 32'd0, 64'd5000400, 3'd2));
        plan.push_back(reg_row(lccs_pkg::CFG_BOOST_CORES, 32'd1));
        plan.push_back(typed_row(lccs_pkg::OP_TOUCH, 32'd0, 64'd6000000, 3'd1,
                                 3'd1, lccs_pkg::ACT_NONE));
        plan.push_back(reg_row(lccs_pkg::CFG_MIN_CORES, 32'd1));
        plan.push_back(reg_row(lccs_pkg::CFG_MAX_CORES, 32'd2));
        plan.push_back(reg_row(lccs_pkg::CFG_BOOST_CORES, 32'd4));
        plan.push_back(typed_row(lccs_pkg::OP_TOUCH, 32'd0, 64'd7000000, 3'd3,
                                 3'd2, lccs_pkg::ACT_HELD));
        plan.push_back(reg_row(lccs_pkg::CFG_BOOST_LOCK_US, 32'd0));
        plan.push_back(item_row(lccs_pkg::OP_SAMPLE, 32'd0, 64'd7000010, 3'd3));
        plan.push_back(reg_row(lccs_pkg::CFG_BOOST_LOCK_US, '1));
        plan.push_back(item_row(lccs_pkg::OP_SAMPLE, 32'd0, 64'd7000020, 3'd3));

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[i]) begin
            r = plan[i];
            if (r.kind == ROW_REG) begin
                settle();
                write_reg(r.idx, r.val);
            end else begin
                send_item(r.it, r.known, r.res);
            end
        end

        sim_now = 64'd8000000;
        for (p = 0; p < PHASES; p++) begin
            settle();
            configure_phase(p);
            tx_idle_pct = (p == 6) ? 0 : 37;
            rx_idle_pct = (p == 6) ? 0 : 37;
            if (p == 7) begin
                sim_now = 64'hFFFF_FFFF_FFF0_0000;
            end else if (p % 2 == 0) begin
                sim_now = {$urandom, $urandom};
            end
            if (p == 5) begin
                stall_hold = 80;
            end
            for (k = 0; k < PHASE_LEN; k++) begin
                send_item(random_item(), 1'b0, none_res);
            end
        end

        settle();
        repeat (10) @(negedge i_clk);
        if (pending_results.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", pending_results.size()));
        end

        $display("Run covered %0d items (%0d touch events) and %0d register writes over %0d phases.",
                 n_items, n_touch, n_regs, PHASES);
        $display("%0d results checked, %0d mismatches.", n_results, n_errors);
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
